[rtl/rgb2hsv_pkg.sv]
// ----------------------------------------------------------------------------
// rgb2hsv_pkg
// Shared types and fixed constants for the RGB to HSV pixel core.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

  // Sector of the largest channel; ties resolve red, then green, then blue.
  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_t;

  localparam int unsigned SECTOR_BITS       = 2;
  // Queue between classifier and divider pipeline.
  localparam int unsigned FRONT_QUEUE_DEPTH = 4;
  // Result queue in front of the output ports.
  localparam int unsigned OUT_QUEUE_DEPTH   = 2;

endpackage

[rtl/rgb2hsv_fifo.sv]
// ----------------------------------------------------------------------------
// rgb2hsv_fifo
// Small register FIFO: push/full on the write side, pop/empty on the read side.
// ----------------------------------------------------------------------------
module rgb2hsv_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_wr   = push & ~full;
  assign do_rd   = pop & ~empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/rgb2hsv_front.sv]
// ----------------------------------------------------------------------------
// rgb2hsv_front
// Pixel classifier: finds max, chroma, dominant sector and the signed
// difference of the other two channels, one pixel per clock while the queue is not full.
// ----------------------------------------------------------------------------
module rgb2hsv_front
  import rgb2hsv_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  output logic                    q_push,
  input  logic                    q_full,
  output logic [CHANNEL_BITS-1:0] q_value,
  output logic [CHANNEL_BITS-1:0] q_chroma,
  output sector_t                 q_sector,
  output logic [CHANNEL_BITS:0]   q_diff
);

  localparam int unsigned CB = CHANNEL_BITS;

  logic          valid_r, valid_nxt;
  logic [CB-1:0] value_r, chroma_r;
  sector_t       sector_r;
  logic [CB:0]   diff_r;

  logic          accept;
  logic [CB-1:0] vmax, vmin;
  sector_t       sect;
  logic [CB:0]   diff;

  assign full   = valid_r & q_full;
  assign accept = push & ~full;
  assign q_push = valid_r;

  always_comb begin
    vmax = red;
    if (green > vmax) vmax = green;
    if (blue > vmax)  vmax = blue;
    vmin = red;
    if (green < vmin) vmin = green;
    if (blue < vmin)  vmin = blue;
  end

  always_comb begin
    priority if (red >= green && red >= blue) begin
      sect = SECT_RED;
      diff = {1'b0, green} - {1'b0, blue};
    end else if (green >= blue) begin
      sect = SECT_GREEN;
      diff = {1'b0, blue} - {1'b0, red};
    end else begin
      sect = SECT_BLUE;
      diff = {1'b0, red} - {1'b0, green};
    end
  end

  assign valid_nxt = accept | (valid_r & q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r  <= vmax;
      chroma_r <= vmax - vmin;
      sector_r <= sect;
      diff_r   <= diff;
    end
  end

  assign q_value  = value_r;
  assign q_chroma = chroma_r;
  assign q_sector = sector_r;
  assign q_diff   = diff_r;

endmodule

[rtl/rgb2hsv_back.sv]
// ----------------------------------------------------------------------------
// rgb2hsv_back
// Divider pipeline: builds hue numerator and saturation dividend, then runs
// two restoring dividers side by side, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rgb2hsv_back
  import rgb2hsv_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = 8,
  parameter int unsigned HUE_BITS     = 16,
  parameter int unsigned SAT_BITS     = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  output logic                    q_pop,
  input  logic [CHANNEL_BITS-1:0] q_value,
  input  logic [CHANNEL_BITS-1:0] q_chroma,
  input  sector_t                 q_sector,
  input  logic [CHANNEL_BITS:0]   q_diff,
  output logic                    o_push,
  input  logic                    o_full,
  output logic [HUE_BITS-1:0]     o_hue,
  output logic [SAT_BITS-1:0]     o_saturation,
  output logic [CHANNEL_BITS-1:0] o_brightness
);

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned HB = HUE_BITS;
  localparam int unsigned SB = SAT_BITS;
  localparam int unsigned NSTAGE = (HB > SB) ? HB : SB;
  localparam int unsigned HW = CB + 3;   // holds 6*chroma

  logic adv;

  // ---- prep stage ----
  logic          pv_r;
  logic [CB-1:0] p_srem_r, p_sdiv_r;
  logic [SB-1:0] p_slow_r;
  logic [HW-1:0] p_hrem_r, p_hdiv_r;
  logic          p_grey_r;

  logic [CB+SB-1:0] sat_dvd;
  logic [HW-1:0]    six_c;
  logic [HW:0]      kc, nsum, nwrap;

  assign sat_dvd = {q_chroma, {SB{1'b0}}} - {{SB{1'b0}}, q_chroma};
  assign six_c   = {1'b0, q_chroma, 2'b00} + {2'b00, q_chroma, 1'b0};

  always_comb begin
    unique case (q_sector)
      SECT_RED:   kc = '0;
      SECT_GREEN: kc = {3'b000, q_chroma, 1'b0};
      SECT_BLUE:  kc = {2'b00, q_chroma, 2'b00};
      default:    kc = '0;
    endcase
    nsum  = kc + {{3{q_diff[CB]}}, q_diff};
    nwrap = nsum[HW] ? nsum + {1'b0, six_c} : nsum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (adv) begin
      pv_r <= ~q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_srem_r <= sat_dvd[CB+SB-1:SB];
      p_slow_r <= sat_dvd[SB-1:0];
      p_sdiv_r <= q_value;
      p_hrem_r <= nwrap[HW-1:0];
      p_hdiv_r <= six_c;
      p_grey_r <= (q_chroma == '0);
    end
  end

  // ---- divider stages ----
  logic          vld_r  [NSTAGE];
  logic [CB-1:0] srem_r [NSTAGE];
  logic [SB-1:0] slow_r [NSTAGE];
  logic [SB-1:0] sq_r   [NSTAGE];
  logic [CB-1:0] sdiv_r [NSTAGE];
  logic [HW-1:0] hrem_r [NSTAGE];
  logic [HB-1:0] hq_r   [NSTAGE];
  logic [HW-1:0] hdiv_r [NSTAGE];
  logic          grey_r [NSTAGE];

  genvar i;
  generate
    for (i = 0; i < NSTAGE; i++) begin : g_stage
      logic          vld_in, grey_in;
      logic [CB-1:0] srem_in, sdiv_in, srem_nxt;
      logic [SB-1:0] slow_in, sq_in, sq_nxt;
      logic [HW-1:0] hrem_in, hdiv_in, hrem_nxt;
      logic [HB-1:0] hq_in, hq_nxt;

      if (i == 0) begin : g_first
        assign vld_in  = pv_r;
        assign srem_in = p_srem_r;
        assign slow_in = p_slow_r;
        assign sq_in   = '0;
        assign sdiv_in = p_sdiv_r;
        assign hrem_in = p_hrem_r;
        assign hq_in   = '0;
        assign hdiv_in = p_hdiv_r;
        assign grey_in = p_grey_r;
      end else begin : g_next
        assign vld_in  = vld_r[i-1];
        assign srem_in = srem_r[i-1];
        assign slow_in = slow_r[i-1];
        assign sq_in   = sq_r[i-1];
        assign sdiv_in = sdiv_r[i-1];
        assign hrem_in = hrem_r[i-1];
        assign hq_in   = hq_r[i-1];
        assign hdiv_in = hdiv_r[i-1];
        assign grey_in = grey_r[i-1];
      end

      if (i < SB) begin : g_sat
        logic [CB:0] trial;
        logic        ge;
        assign trial    = {srem_in, slow_in[SB-1-i]};
        assign ge       = (trial >= {1'b0, sdiv_in});
        assign srem_nxt = ge ? CB'(trial - {1'b0, sdiv_in}) : trial[CB-1:0];
        assign sq_nxt   = {sq_in[SB-2:0], ge};
      end else begin : g_sat_hold
        assign srem_nxt = srem_in;
        assign sq_nxt   = sq_in;
      end

      if (i < HB) begin : g_hue
        logic [HW:0] trial;
        logic        ge;
        assign trial    = {hrem_in, 1'b0};
        assign ge       = (trial >= {1'b0, hdiv_in});
        assign hrem_nxt = ge ? HW'(trial - {1'b0, hdiv_in}) : trial[HW-1:0];
        assign hq_nxt   = {hq_in[HB-2:0], ge};
      end else begin : g_hue_hold
        assign hrem_nxt = hrem_in;
        assign hq_nxt   = hq_in;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else if (adv) begin
          vld_r[i] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          srem_r[i] <= srem_nxt;
          slow_r[i] <= slow_in;
          sq_r[i]   <= sq_nxt;
          sdiv_r[i] <= sdiv_in;
          hrem_r[i] <= hrem_nxt;
          hq_r[i]   <= hq_nxt;
          hdiv_r[i] <= hdiv_in;
          grey_r[i] <= grey_in;
        end
      end
    end
  endgenerate

  // Whole pipeline moves together; it holds only when the last word can't leave.
  assign adv    = ~vld_r[NSTAGE-1] | ~o_full;
  assign q_pop  = adv;
  assign o_push = vld_r[NSTAGE-1];

  assign o_hue        = grey_r[NSTAGE-1] ? '0 : hq_r[NSTAGE-1];
  assign o_saturation = grey_r[NSTAGE-1] ? '0 : sq_r[NSTAGE-1];
  assign o_brightness = sdiv_r[NSTAGE-1];

endmodule

[rtl/rgb_to_hsv_pixel_core.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_core
// RGB to HSV conversion with queue interfaces; one pixel word per clock unless results back up.
// ----------------------------------------------------------------------------
// Push an RGB word when in_full is low; results come out in order on the
// out_ ports while out_empty is low and are taken with out_pop. Throughput
// is one pixel per clock while results are popped as they appear; when
// they back up, in_full holds the input. A word passes through the
// classifier register, front queue, numerator/dividend prep, then one stage
// per quotient bit of the two restoring dividers, then the result queue.
// Brightness is the largest channel. Saturation is floor(C*(2^SAT_BITS-1)/V)
// with C = max - min. Hue is the fraction of a turn times 2^HUE_BITS,
// truncated, taken from the sector of the largest channel (ties: red, then
// green, then blue). Black and grey pixels give hue and saturation of zero.
// No reset-time sweep; the core accepts words right after reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_core
  import rgb2hsv_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = 8,
  parameter int unsigned HUE_BITS     = 16,
  parameter int unsigned SAT_BITS     = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // pixel input
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [CHANNEL_BITS-1:0] in_red,
  input  logic [CHANNEL_BITS-1:0] in_green,
  input  logic [CHANNEL_BITS-1:0] in_blue,
  // result output
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [HUE_BITS-1:0]     out_hue,
  output logic [SAT_BITS-1:0]     out_saturation,
  output logic [CHANNEL_BITS-1:0] out_brightness
);

  localparam int unsigned CB  = CHANNEL_BITS;
  // front queue word: value, chroma, sector, signed diff
  localparam int unsigned FQW = CB + CB + SECTOR_BITS + CB + 1;
  // result word: hue, saturation, brightness
  localparam int unsigned OQW = HUE_BITS + SAT_BITS + CB;

  // classifier -> queue
  logic          f_push, f_full;
  logic [CB-1:0] f_value, f_chroma;
  sector_t       f_sector;
  logic [CB:0]   f_diff;

  // queue -> divider pipeline
  logic           b_pop, b_empty;
  logic [FQW-1:0] fq_wr, fq_rd;

  // divider pipeline -> result queue
  logic                o_push, o_full;
  logic [HUE_BITS-1:0] o_hue;
  logic [SAT_BITS-1:0] o_sat;
  logic [CB-1:0]       o_bright;
  logic [OQW-1:0]      oq_wr, oq_rd;

  rgb2hsv_front #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .full     (in_full),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .q_push   (f_push),
    .q_full   (f_full),
    .q_value  (f_value),
    .q_chroma (f_chroma),
    .q_sector (f_sector),
    .q_diff   (f_diff)
  );

  assign fq_wr = {f_value, f_chroma, f_sector, f_diff};

  // decouples classification from the divider pipeline
  rgb2hsv_fifo #(
    .WIDTH (FQW),
    .DEPTH (FRONT_QUEUE_DEPTH)
  ) u_front_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wr_data (fq_wr),
    .full    (f_full),
    .pop     (b_pop),
    .rd_data (fq_rd),
    .empty   (b_empty)
  );

  rgb2hsv_back #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .HUE_BITS     (HUE_BITS),
    .SAT_BITS     (SAT_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (b_empty),
    .q_pop        (b_pop),
    .q_value      (fq_rd[FQW-1 -: CB]),
    .q_chroma     (fq_rd[FQW-CB-1 -: CB]),
    .q_sector     (sector_t'(fq_rd[CB+SECTOR_BITS:CB+1])),
    .q_diff       (fq_rd[CB:0]),
    .o_push       (o_push),
    .o_full       (o_full),
    .o_hue        (o_hue),
    .o_saturation (o_sat),
    .o_brightness (o_bright)
  );

  assign oq_wr = {o_hue, o_sat, o_bright};

  // result skid queue: pipeline keeps moving while a finished word waits
  rgb2hsv_fifo #(
    .WIDTH (OQW),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (o_push),
    .wr_data (oq_wr),
    .full    (o_full),
    .pop     (out_pop),
    .rd_data (oq_rd),
    .empty   (out_empty)
  );

  assign out_hue        = oq_rd[OQW-1 -: HUE_BITS];
  assign out_saturation = oq_rd[CB+SAT_BITS-1 -: SAT_BITS];
  assign out_brightness = oq_rd[CB-1:0];

endmodule

[verif/hsv_result_checker.sv]
// ----------------------------------------------------------------------------
// hsv_result_checker
// Watches both queue ports of the RGB to HSV core, predicts and compares.
// ----------------------------------------------------------------------------
// Every pixel word pushed into the core is converted here in exact integer
// arithmetic and queued. Every result word popped is compared field by field
// with the oldest queued prediction. Mismatches and stray words are counted.
// ----------------------------------------------------------------------------
module hsv_result_checker
  import rgb2hsv_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = 8,
  parameter int unsigned HUE_BITS     = 16,
  parameter int unsigned SAT_BITS     = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  logic                    in_full,
  input  logic [CHANNEL_BITS-1:0] in_red,
  input  logic [CHANNEL_BITS-1:0] in_green,
  input  logic [CHANNEL_BITS-1:0] in_blue,
  input  logic                    out_empty,
  input  logic                    out_pop,
  input  logic [HUE_BITS-1:0]     out_hue,
  input  logic [SAT_BITS-1:0]     out_saturation,
  input  logic [CHANNEL_BITS-1:0] out_brightness,
  output int unsigned             fail_count,
  output int unsigned             words_in_flight,
  output int unsigned             words_checked,
  output int unsigned             red_hits,
  output int unsigned             green_hits,
  output int unsigned             blue_hits,
  output int unsigned             grey_hits,
  output int unsigned             wrap_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [HUE_BITS-1:0]     hue;
    logic [SAT_BITS-1:0]     saturation;
    logic [CHANNEL_BITS-1:0] brightness;
  } hsv_word_t;

  hsv_word_t pending_hsv[$];
  hsv_word_t predicted;
  hsv_word_t oldest;
  sector_t   pix_sector;
  bit        pix_wrapped;
  bit        pix_grey;

  // Exact integer HSV of one pixel; hue numerator is k*C + d, wrapped once.
  function automatic hsv_word_t hsv_of_pixel(
    input  logic [CHANNEL_BITS-1:0] r,
    input  logic [CHANNEL_BITS-1:0] g,
    input  logic [CHANNEL_BITS-1:0] b,
    output sector_t                 sect,
    output bit                      wrapped,
    output bit                      grey
  );
    hsv_word_t w;
    longint    rl, gl, bl, v, m, c, n, sat_max;
    w       = '0;
    w.red   = r;
    w.green = g;
    w.blue  = b;
    rl      = longint'(r);
    gl      = longint'(g);
    bl      = longint'(b);
    sat_max = (longint'(1) << SAT_BITS) - 1;
    v = rl;
    if (gl > v) v = gl;
    if (bl > v) v = bl;
    m = rl;
    if (gl < m) m = gl;
    if (bl < m) m = bl;
    c = v - m;
    // ties: red wins over green, green over blue
    if (v == rl) sect = SECT_RED;
    else if (v == gl) sect = SECT_GREEN;
    else sect = SECT_BLUE;
    wrapped      = 1'b0;
    grey         = (c == 0);
    w.brightness = v[CHANNEL_BITS-1:0];
    if (c != 0) begin
      w.saturation = SAT_BITS'((c * sat_max) / v);
      case (sect)
        SECT_RED:   n = gl - bl;
        SECT_GREEN: n = 2 * c + bl - rl;
        default:    n = 4 * c + rl - gl;
      endcase
      if (n < 0) begin
        n       = n + 6 * c;
        wrapped = 1'b1;
      end
      w.hue = HUE_BITS'((n << HUE_BITS) / (6 * c));
    end
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_hsv.delete();
      fail_count      = 0;
      words_in_flight = 0;
      words_checked   = 0;
      red_hits        = 0;
      green_hits      = 0;
      blue_hits       = 0;
      grey_hits       = 0;
      wrap_hits       = 0;
    end else begin
      if (in_push && !in_full) begin
        predicted = hsv_of_pixel(in_red, in_green, in_blue,
                                 pix_sector, pix_wrapped, pix_grey);
        pending_hsv.push_back(predicted);
        if (pix_grey) grey_hits++;
        else if (pix_sector == SECT_RED) red_hits++;
        else if (pix_sector == SECT_GREEN) green_hits++;
        else blue_hits++;
        if (pix_wrapped) wrap_hits++;
      end
      if (out_pop && !out_empty) begin
        if (pending_hsv.size() == 0) begin
          report_mismatch("result word popped with no pixel outstanding");
        end else begin
          oldest = pending_hsv.pop_front();
          words_checked++;
          if (out_hue !== oldest.hue)
            report_mismatch($sformatf("rgb %0d,%0d,%0d hue want %0d got %0d",
              oldest.red, oldest.green, oldest.blue, oldest.hue, out_hue));
          if (out_saturation !== oldest.saturation)
            report_mismatch($sformatf("rgb %0d,%0d,%0d saturation want %0d got %0d",
              oldest.red, oldest.green, oldest.blue, oldest.saturation,
              out_saturation));
          if (out_brightness !== oldest.brightness)
            report_mismatch($sformatf("rgb %0d,%0d,%0d brightness want %0d got %0d",
              oldest.red, oldest.green, oldest.blue, oldest.brightness,
              out_brightness));
        end
      end
      words_in_flight = pending_hsv.size();
    end
  end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Pixel stream test of the RGB to HSV core against an integer predictor.
// ----------------------------------------------------------------------------
// A directed list of corner pixels (black, grey, pure primaries, every tie for
// the largest channel, hue wrap-around) is followed by random pixels mixed
// from uniform, grey, tied, extreme and near-grey colors. The pixel side
// pushes in bursts with random gaps; the result side pops on a pattern that
// cycles through full rate, coin toss, sparse pops and long stalls. Checking
// lives in hsv_result_checker; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB            = 8;
  localparam int unsigned HB            = 16;
  localparam int unsigned SB            = 16;
  localparam int unsigned CHAN_MAX      = (1 << CB) - 1;
  localparam int unsigned RANDOM_PIXELS = 1300;
  // drain wait for the tail of the pipe, with slack past its depth
  localparam int unsigned DRAIN_CYCLES  = 2 * ((HB > SB ? HB : SB) + 4);
  // longest legal quiet spell: sender gap + receiver stall + pipe latency;
  // the limit is many times that
  localparam int unsigned IDLE_LIMIT    = 2000;

  // corner pixels, packed {red, green, blue}
  localparam logic [3*CB-1:0] DIRECTED_PIXELS [20] = '{
    24'h000000,  // black
    24'hffffff,  // white: grey at full scale
    24'h808080,  // mid grey
    24'h010101,  // faintest grey
    24'hff0000,  // pure red
    24'h00ff00,  // pure green
    24'h0000ff,  // pure blue
    24'hff000a,  // red sector, green below blue: hue wraps
    24'hffff00,  // red/green tie goes to red
    24'h00ffff,  // green/blue tie goes to green
    24'hff00ff,  // red/blue tie goes to red, wraps
    24'h0ac805,  // green sector
    24'h0307fa,  // blue sector
    24'h010000,  // smallest nonzero value
    24'h000001,
    24'hfffefe,  // tiny chroma at full value
    24'hfeff00,  // green sector, negative difference
    24'h0100ff,  // blue sector, red above green
    24'h00ff01,
    24'hff8040
  };
  localparam logic [CB-1:0] EXTREME_VALS [4] = '{8'd0, 8'd1, 8'd254, 8'd255};

  logic          clk;
  logic          rst_n    = 1'b0;
  logic          in_push  = 1'b0;
  logic          in_full;
  logic [CB-1:0] in_red   = '0;
  logic [CB-1:0] in_green = '0;
  logic [CB-1:0] in_blue  = '0;
  logic          out_empty;
  logic          out_pop  = 1'b0;
  logic [HB-1:0] out_hue;
  logic [SB-1:0] out_saturation;
  logic [CB-1:0] out_brightness;

  int unsigned fail_count, words_in_flight, words_checked;
  int unsigned red_hits, green_hits, blue_hits, grey_hits, wrap_hits;

  int unsigned pixels_sent  = 0;
  int unsigned burst_left   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned pop_cycle    = 0;
  int unsigned stall_left   = 0;

  rgb_to_hsv_pixel_core #(
    .CHANNEL_BITS (CB),
    .HUE_BITS     (HB),
    .SAT_BITS     (SB)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  hsv_result_checker #(
    .CHANNEL_BITS (CB),
    .HUE_BITS     (HB),
    .SAT_BITS     (SB)
  ) hsv_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_hue         (out_hue),
    .out_saturation  (out_saturation),
    .out_brightness  (out_brightness),
    .fail_count      (fail_count),
    .words_in_flight (words_in_flight),
    .words_checked   (words_checked),
    .red_hits        (red_hits),
    .green_hits      (green_hits),
    .blue_hits       (blue_hits),
    .grey_hits       (grey_hits),
    .wrap_hits       (wrap_hits)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Called at a falling edge before each word. Opens a new burst when the
  // old one is used up, with a gap in front of it (sometimes none, so bursts
  // run together). push is dropped only when a real gap follows, so it never
  // falls and rises in the same step.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Present one pixel word from a falling edge and hold it until a rising
  // edge takes it (push high, full low). Returns at the next falling edge.
  task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                            input logic [CB-1:0] b);
    pace_sender();
    in_push  <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Receiver pattern: four modes in rotation -- pop every cycle, coin toss,
  // one in four, and mostly-pop with random stalls.
  always @(negedge clk) begin
    pop_cycle <= pop_cycle + 1;
    case ((pop_cycle / 97) % 4)
      0: out_pop <= 1'b1;
      1: out_pop <= ($urandom_range(0, 1) == 1);
      2: out_pop <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left != 0) begin
          out_pop    <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          out_pop <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 24);
        end
      end
    endcase
  end

  // Watchdog: any word moving on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned   kind;
    int unsigned   pick;
    logic [CB-1:0] r, g, b, hi, lo;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED_PIXELS[i])
      send_pixel(DIRECTED_PIXELS[i][3*CB-1:2*CB], DIRECTED_PIXELS[i][2*CB-1:CB],
                 DIRECTED_PIXELS[i][CB-1:0]);

    // random mix: half uniform, the rest aimed at greys, ties, extremes
    // and tiny chroma where the dividers see awkward operands
    repeat (RANDOM_PIXELS) begin
      kind = $urandom_range(0, 9);
      r = CB'($urandom_range(0, CHAN_MAX));
      g = CB'($urandom_range(0, CHAN_MAX));
      b = CB'($urandom_range(0, CHAN_MAX));
      case (kind)
        5: begin
          g = r;
          b = r;
        end
        6: begin
          // two channels tie for largest, third at or below them
          hi   = CB'($urandom_range(1, CHAN_MAX));
          lo   = CB'($urandom_range(0, hi));
          pick = $urandom_range(0, 2);
          r    = (pick == 2) ? lo : hi;
          g    = (pick == 1) ? lo : hi;
          b    = (pick == 0) ? lo : hi;
        end
        7: begin
          r = EXTREME_VALS[$urandom_range(0, 3)];
          g = EXTREME_VALS[$urandom_range(0, 3)];
          b = EXTREME_VALS[$urandom_range(0, 3)];
        end
        8: begin
          r = CB'($urandom_range(0, 3));
          g = CB'($urandom_range(0, 3));
          b = CB'($urandom_range(0, 3));
        end
        9: begin
          // near grey: flip only the two low bits
          g = r ^ CB'($urandom_range(0, 3));
          b = r ^ CB'($urandom_range(0, 3));
        end
        default: ;
      endcase
      send_pixel(r, g, b);
    end

    in_push <= 1'b0;
    while (words_in_flight != 0) @(negedge clk);
    // let any stray extra word surface before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d pixels (%0d corner cases), %0d result words compared.",
             pixels_sent, $size(DIRECTED_PIXELS), words_checked);
    $display("Largest channel red/green/blue %0d/%0d/%0d, grey %0d, hue wrap %0d.",
             red_hits, green_hits, blue_hits, grey_hits, wrap_hits);
    if (fail_count == 0 && words_in_flight == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
